@@ rtl/elg_pkg.sv @@
// ----------------------------------------------------------------------------
// elg_pkg
// shared types and constants for the modular exponentiation engine
// ----------------------------------------------------------------------------
package elg_pkg;

    localparam int W     = 32;
    localparam int CNT_W = $clog2(W);

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_KEY       = 2'd1;
    localparam logic [1:0] REG_GENERATOR = 2'd2;

    localparam logic REQ_ENCRYPT = 1'b0;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDB,
        ST_PLOOP,
        ST_PMUL,
        ST_PSQR,
        ST_EDIV,
        ST_EMUL,
        ST_ECHK,
        ST_FMOD,
        ST_FMUL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_PK,
        PH_C1,
        PH_PT,
        PH_S
    } phase_t;

endpackage

@@ rtl/elgamal_modexp_engine.sv @@
// ----------------------------------------------------------------------------
// elgamal_modexp_engine
// textbook elgamal encrypt and decrypt over integers modulo a configured modulus
// ----------------------------------------------------------------------------
// One request at a time. Every step runs on one shared bit-serial unit that
// does one modular multiply or divide at a time: the public key and each further
// exponentiation need one reduction plus up to two multiplies per exponent bit,
// decryption adds an extended euclid inverse (one divide and one multiply per
// quotient step). A modulus below two skips the arithmetic and goes straight
// to the output. s_tready is high only while the engine is idle.
module elgamal_modexp_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // message, random_exp, cipher_a, cipher_b
    input  logic         s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // c1_out, c2_out, public_key, plaintext
    output logic         m_tuser    // no_inverse
);
    import elg_pkg::*;

    logic [W-1:0] modulus_reg, key_reg, gen_reg;

    state_t       st_reg, st_next;
    phase_t       ph_reg, ph_next;
    logic         issued_reg, issued_next;
    logic         req_reg, req_next;
    logic [W-1:0] msg_reg, msg_next, rexp_reg, rexp_next;
    logic [W-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [W-1:0] m_reg, m_next, pk_reg, pk_next;
    logic [W-1:0] base_reg, base_next, ex_reg, ex_next, acc_reg, acc_next;
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next, t0_reg, t0_next, t1_reg, t1_next;
    logic [W-1:0] tmp_reg, tmp_next, sec_reg, sec_next;
    logic [W-1:0] c1_reg, c1_next, res_reg, res_next;
    logic         flag_reg, flag_next;

    logic         ov_reg, ov_next;
    logic [127:0] od_reg, od_next;
    logic         of_reg, of_next;

    unit_cmd_t    cmd;
    unit_sts_t    sts;
    logic [W-1:0] ua, ub, ures, uquot, qm, t2;
    logic         need;

    elg_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (ua),
        .b      (ub),
        .m      (m_reg),
        .sts    (sts),
        .result (ures),
        .quot   (uquot)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == ST_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = od_reg;
    assign m_tuser   = of_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(2);
            key_reg     <= '0;
            gen_reg     <= W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODULUS:   modulus_reg <= cfg_data;
                REG_KEY:       key_reg     <= cfg_data;
                REG_GENERATOR: gen_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign qm = (tmp_reg == m_reg) ? '0 : tmp_reg;
    assign t2 = (t0_reg >= ures) ? t0_reg - ures : t0_reg + (m_reg - ures);

    always_comb
    begin
        st_next = st_reg;   ph_next = ph_reg;   issued_next = issued_reg;
        req_next = req_reg; msg_next = msg_reg; rexp_next = rexp_reg;
        ca_next = ca_reg;   cb_next = cb_reg;   m_next = m_reg;   pk_next = pk_reg;
        base_next = base_reg; ex_next = ex_reg; acc_next = acc_reg;
        r0_next = r0_reg;   r1_next = r1_reg;   t0_next = t0_reg; t1_next = t1_reg;
        tmp_next = tmp_reg; sec_next = sec_reg; c1_next = c1_reg;
        res_next = res_reg; flag_next = flag_reg;
        ov_next = ov_reg;   od_next = od_reg;   of_next = of_reg;
        need = 1'b0;
        cmd.op = OP_MUL;
        ua = acc_reg;
        ub = base_reg;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next  = s_tuser;
                    msg_next  = s_tdata[31:0];
                    rexp_next = s_tdata[63:32];
                    ca_next   = s_tdata[95:64];
                    cb_next   = s_tdata[127:96];
                    m_next    = modulus_reg;
                    c1_next   = '0;
                    res_next  = '0;
                    pk_next   = '0;
                    flag_next = 1'b0;
                    if (modulus_reg < W'(2))
                    begin
                        flag_next = s_tuser;
                        st_next   = ST_OUT;
                    end
                    else
                    begin
                        ph_next   = PH_PK;
                        base_next = gen_reg;
                        ex_next   = key_reg;
                        st_next   = ST_REDB;
                    end
                end
            end
            ST_REDB:
            begin
                need = 1'b1; cmd.op = OP_DIV; ua = base_reg; ub = m_reg;
                if (sts.done)
                begin
                    base_next = ures;
                    acc_next  = W'(1);
                    st_next   = ST_PLOOP;
                end
            end
            ST_PLOOP:
            begin
                if (ex_reg != '0)
                begin
                    st_next = ex_reg[0] ? ST_PMUL : ST_PSQR;
                end
                else
                begin
                    unique case (ph_reg)
                        PH_PK:
                        begin
                            pk_next = acc_reg;
                            st_next = ST_REDB;
                            if (req_reg == REQ_ENCRYPT)
                            begin
                                ph_next = PH_C1; base_next = gen_reg; ex_next = rexp_reg;
                            end
                            else
                            begin
                                ph_next = PH_S; base_next = ca_reg; ex_next = key_reg;
                            end
                        end
                        PH_C1:
                        begin
                            c1_next = acc_reg; ph_next = PH_PT;
                            base_next = pk_reg; ex_next = rexp_reg; st_next = ST_REDB;
                        end
                        PH_PT:
                        begin
                            sec_next = acc_reg; st_next = ST_FMOD;
                        end
                        PH_S:
                        begin
                            r0_next = m_reg; r1_next = acc_reg;
                            t0_next = '0;    t1_next = W'(1);
                            st_next = ST_EDIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PMUL:
            begin
                need = 1'b1;
                if (sts.done)
                begin
                    acc_next = ures;
                    st_next  = ST_PSQR;
                end
            end
            ST_PSQR:
            begin
                if (ex_reg[W-1:1] == '0)
                begin
                    ex_next = '0;
                    st_next = ST_PLOOP;
                end
                else
                begin
                    need = 1'b1; ua = base_reg;
                    if (sts.done)
                    begin
                        base_next = ures;
                        ex_next   = ex_reg >> 1;
                        st_next   = ST_PLOOP;
                    end
                end
            end
            ST_EDIV:
            begin
                if (r1_reg == '0)
                begin
                    st_next = ST_ECHK;
                end
                else
                begin
                    need = 1'b1; cmd.op = OP_DIV; ua = r0_reg; ub = r1_reg;
                    if (sts.done)
                    begin
                        tmp_next = uquot;
                        r0_next  = r1_reg;
                        r1_next  = ures;
                        st_next  = ST_EMUL;
                    end
                end
            end
            ST_EMUL:
            begin
                need = 1'b1; ua = qm; ub = t1_reg;
                if (sts.done)
                begin
                    t0_next = t1_reg;
                    t1_next = t2;
                    st_next = ST_EDIV;
                end
            end
            ST_ECHK:
            begin
                if (r0_reg == W'(1))
                begin
                    sec_next = t0_reg;
                    st_next  = ST_FMOD;
                end
                else
                begin
                    flag_next = 1'b1;
                    st_next   = ST_OUT;
                end
            end
            ST_FMOD:
            begin
                need = 1'b1; cmd.op = OP_DIV; ub = m_reg;
                ua = (req_reg == REQ_ENCRYPT) ? msg_reg : cb_reg;
                if (sts.done)
                begin
                    tmp_next = ures;
                    st_next  = ST_FMUL;
                end
            end
            ST_FMUL:
            begin
                need = 1'b1; ua = sec_reg; ub = tmp_reg;
                if (sts.done)
                begin
                    res_next = ures;
                    st_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    of_next = flag_reg;
                    if (req_reg == REQ_ENCRYPT)
                    begin
                        od_next = {W'(0), pk_reg, res_reg, c1_reg};
                    end
                    else
                    begin
                        od_next = {res_reg, pk_reg, W'(0), W'(0)};
                    end
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase

        cmd.start = need && !issued_reg;
        if (cmd.start)
        begin
            issued_next = 1'b1;
        end
        if (sts.done)
        begin
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            issued_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            issued_reg <= issued_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg <= ph_next;   req_reg <= req_next;   msg_reg <= msg_next;
        rexp_reg <= rexp_next; ca_reg <= ca_next;   cb_reg <= cb_next;
        m_reg <= m_next;     pk_reg <= pk_next;     base_reg <= base_next;
        ex_reg <= ex_next;   acc_reg <= acc_next;   r0_reg <= r0_next;
        r1_reg <= r1_next;   t0_reg <= t0_next;     t1_reg <= t1_next;
        tmp_reg <= tmp_next; sec_reg <= sec_next;   c1_reg <= c1_next;
        res_reg <= res_next; flag_reg <= flag_next;
        od_reg <= od_next;   of_reg <= of_next;
    end

    a_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_IDLE |-> !issued_reg && !sts.busy)
        else $error("unit busy while idle");

    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> issued_reg)
        else $error("unit finished without a request");

    a_euclid_order: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_EDIV |-> r1_reg < r0_reg)
        else $error("remainder not below divisor");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_PLOOP |-> acc_reg < m_reg && base_reg < m_reg)
        else $error("exponent operands not reduced");

endmodule

@@ rtl/elg_arith.sv @@
// ----------------------------------------------------------------------------
// elg_arith
// shared bit-serial unit: modular multiply by add-and-double, or restoring divide
// ----------------------------------------------------------------------------
module elg_arith (
    input  logic                    clk,
    input  logic                    rst_n,
    input  elg_pkg::unit_cmd_t      cmd,
    input  logic [elg_pkg::W-1:0]   a,
    input  logic [elg_pkg::W-1:0]   b,
    input  logic [elg_pkg::W-1:0]   m,
    output elg_pkg::unit_sts_t      sts,
    output logic [elg_pkg::W-1:0]   result,
    output logic [elg_pkg::W-1:0]   quot
);
    import elg_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    op_t              op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     m_reg, m_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     q_reg, q_next;

    logic [W:0]   dbl, dbl_red, sum, sum_red, rem, rem_sub;
    logic [W-1:0] mul_val, div_val;
    logic         div_ge;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
        mul_val = b_reg[cnt_reg] ? sum_red[W-1:0] : dbl_red[W-1:0];
        rem     = {acc_reg, a_reg[cnt_reg]};
        div_ge  = rem >= {1'b0, b_reg};
        rem_sub = div_ge ? rem - {1'b0, b_reg} : rem;
        div_val = rem_sub[W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = CNT_W'(W - 1);
            a_next    = a;
            b_next    = b;
            m_next    = m;
            acc_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                acc_next = mul_val;
            end
            else
            begin
                acc_next         = div_val;
                q_next[cnt_reg]  = div_ge;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = acc_reg;
    assign quot     = q_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// elgamal engine test: directed and random encrypt and decrypt requests under
// several register settings, checked against a behavioral model of the group
// arithmetic, with random sender bursts, receiver stalls and a long hold-off
// ----------------------------------------------------------------------------
module tb;
    import elg_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // message, random_exp, cipher_a, cipher_b
    logic         s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // c1_out, c2_out, public_key, plaintext
    logic         m_tuser;   // no_inverse

    typedef struct packed {
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] pk;
        logic [31:0] pt;
        logic        flag;
    } elg_result_t;

    elg_result_t expected_q[$];
    logic [31:0] mod_r;
    logic [31:0] key_r;
    logic [31:0] gen_r;
    int          errors;
    int          hold_off;
    bit          stall_on;

    elgamal_modexp_engine DUT (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = a * b;
        return p % m;
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mulmod(acc, b, m);
            e = e >> 1;
            b = mulmod(b, b, m);
        end
        return acc;
    endfunction

    function automatic elg_result_t elgamal_predict(logic req, logic [127:0] d);
        elg_result_t r;
        logic [63:0] m, s, r0, r1, t0, t1, q, tmp;
        r = '0;
        m = mod_r;
        if (m >= 2)
        begin
            r.pk = powmod(gen_r, key_r, m);
            if (req == REQ_ENCRYPT)
            begin
                r.c1 = powmod(gen_r, d[63:32], m);
                r.c2 = mulmod(powmod(r.pk, d[63:32], m), d[31:0] % m, m);
            end
            else
            begin
                s = powmod(d[95:64], key_r, m);
                r0 = m; r1 = s; t0 = 0; t1 = 1;
                while (r1 != 0)
                begin
                    q = r0 / r1;
                    tmp = r0 - q * r1; r0 = r1; r1 = tmp;
                    tmp = (t0 + m - mulmod(q % m, t1, m)) % m; t0 = t1; t1 = tmp;
                end
                if (r0 == 1)
                    r.pt = mulmod(d[127:96] % m, t0, m);
                else
                    r.flag = 1'b1;
            end
        end
        else if (req != REQ_ENCRYPT)
            r.flag = 1'b1;
        return r;
    endfunction

    task automatic send_request(logic req, logic [127:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(elgamal_predict(req, d));
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODULUS:   mod_r = val;
            REG_KEY:       key_r = val;
            REG_GENERATOR: gen_r = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_group(logic [31:0] p, logic [31:0] d, logic [31:0] g);
        drain();
        write_reg(REG_MODULUS, p);
        write_reg(REG_KEY, d);
        write_reg(REG_GENERATOR, g);
    endtask

    function automatic logic [127:0] rand_data();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic test_reset_defaults();
        send_request(REQ_ENCRYPT, rand_data());
        send_request(~REQ_ENCRYPT, rand_data());
    endtask

    task automatic test_directed();
        set_group(32'd23, 32'd6, 32'd5);
        send_request(REQ_ENCRYPT, {32'd0, 32'd0, 32'd0, 32'd10});
        send_request(REQ_ENCRYPT, {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        send_request(REQ_ENCRYPT, {96'd0, 32'd0});
        send_request(~REQ_ENCRYPT, {32'd7, 32'd0, 64'd0});
        send_request(~REQ_ENCRYPT, {32'd7, 32'd23, 64'd0});
        send_request(~REQ_ENCRYPT, {32'hffffffff, 32'hffffffff, 64'hffffffffffffffff});
        set_group(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_request(REQ_ENCRYPT, {128{1'b1}});
        send_request(~REQ_ENCRYPT, {32'h12345678, 32'h3, 64'd0});
        send_request(~REQ_ENCRYPT, {32'h1, 32'h5, 64'd0});
        set_group(32'd1, 32'd5, 32'd3);
        send_request(REQ_ENCRYPT, rand_data());
        send_request(~REQ_ENCRYPT, rand_data());
        set_group(32'd0, 32'd0, 32'd0);
        send_request(REQ_ENCRYPT, rand_data());
        send_request(~REQ_ENCRYPT, rand_data());
        set_group(32'd2, 32'd0, 32'd2);
        send_request(REQ_ENCRYPT, {96'd0, 32'd1});
        send_request(~REQ_ENCRYPT, {32'd1, 32'd1, 64'd0});
    endtask

    task automatic test_random(int n, logic [31:0] p, logic [31:0] d, logic [31:0] g);
        set_group(p, d, g);
        repeat (n)
            send_request(logic'($urandom_range(0, 1)), rand_data());
    endtask

    task automatic test_backpressure();
        set_group(32'd65521, 32'd1234, 32'd17);
        hold_off = 30000;
        repeat (4)
            send_request(logic'($urandom_range(0, 1)), rand_data());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h %b", m_tdata, m_tuser);
            end
            else
            begin
                elg_result_t e;
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.c1 || m_tdata[63:32] !== e.c2 ||
                    m_tdata[95:64] !== e.pk || m_tdata[127:96] !== e.pt ||
                    m_tuser !== e.flag)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp c1 %h c2 %h pk %h pt %h f %b got %h %b",
                                 e.c1, e.c2, e.pk, e.pt, e.flag, m_tdata, m_tuser);
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_on <= ~stall_on;
            m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        stall_on  = 1'b0;
        hold_off  = 0;
        errors    = 0;
        mod_r     = 32'd2;
        key_r     = 32'd0;
        gen_r     = 32'd2;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random(30, 32'd4294967291, $urandom, $urandom);
        test_random(25, 32'd1000, $urandom, $urandom_range(0, 999));
        test_random(25, $urandom_range(2, 300), $urandom_range(0, 50), $urandom);
        test_random(20, $urandom | 32'h80000000, $urandom, $urandom);
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
